### hw/rtl/ais_pkg.sv
// Shared constants and types of the ascending integer sorter.
package ais_pkg;

  localparam int unsigned DataWidth       = 32;
  localparam int unsigned DefaultCapacity = 64;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the new value, shift larger values right
    logic shift;   // move every value one cell toward the head
  } ais_ctrl_t;

endpackage

### hw/rtl/ais_cell.sv
// One cell of the sorting chain: holds one value, compares and shifts.
module ais_cell (
  input  logic                                clk_i,
  input  ais_pkg::ais_ctrl_t                  ctrl_i,
  input  logic                                occupied_i,
  input  logic signed [ais_pkg::DataWidth-1:0] new_value_i,
  input  logic signed [ais_pkg::DataWidth-1:0] left_value_i,
  input  logic                                left_gt_i,
  input  logic signed [ais_pkg::DataWidth-1:0] right_value_i,
  output logic signed [ais_pkg::DataWidth-1:0] value_o,
  output logic                                gt_o
);
  import ais_pkg::*;

  logic signed [DataWidth-1:0] value_q, value_d;

  // An empty cell counts as larger than anything.
  assign gt_o    = !occupied_i || (value_q > new_value_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert && gt_o) begin
      value_d = left_gt_i ? left_value_i : new_value_i;
    end else if (ctrl_i.shift) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

### hw/rtl/ascending_integer_sorter.sv
// Top level of the ascending integer sorter: cell chain and control.
//
// Usage:
//   Input channel: a transaction is taken at a rising edge where start is
//   high and busy is low. Each transaction carries one signed value and a
//   last_item_i flag that closes the set.
//   Insertion broadcasts each accepted value to a chain
//   of CAPACITY cells, every cell compares it against its own value, and
//   larger values move one cell right, so the chain stays sorted at all
//   times. Values arriving while the chain is full are dropped and the set
//   is marked as overflowed.
//   After the closing transaction, busy rises and the chain drains:
//   one result per kept value. Each drain cycle presents one result
//   (result_valid_o high) taken from the head cell while the chain shifts
//   toward the head. last_result_o marks the final one, overflowed_o is
//   high on every result of an overflowed set. busy falls in the cycle
//   after the final result.
//   The receiver cannot stall: each result stands for exactly one cycle.
//   Reset clears the fill count, overflow flag and control state; the cell
//   contents need no reset since only occupied cells are ever read.
module ascending_integer_sorter #(
  parameter int unsigned CAPACITY = ais_pkg::DefaultCapacity
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ais_pkg::DataWidth-1:0] value_i,
  input  logic                                last_item_i,
  output logic                                result_valid_o,
  output logic signed [ais_pkg::DataWidth-1:0] sorted_value_o,
  output logic                                last_result_o,
  output logic                                overflowed_o
);
  import ais_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StDrain = 2'b10
  } ais_state_e;

  ais_state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            accept, full;
  ais_ctrl_t       ctrl;

  logic signed [DataWidth-1:0] cell_value [CAPACITY];
  logic                        cell_gt    [CAPACITY];

  assign busy   = (state_q == StDrain);
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(CAPACITY));

  // Drop the value when full; otherwise every cell takes part in the insert.
  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = busy;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (last_item_i) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        count_d = count_q - CntW'(1);
        if (count_q == CntW'(1)) begin
          // Final result leaves now: start a fresh set.
          state_d = StIdle;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Cell chain: head at index 0 holds the smallest value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataWidth-1:0] left_value, right_value;
    logic                        left_gt;

    if (i == 0) begin : g_head
      assign left_value = value_i;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    ais_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (CntW'(i) < count_q),
      .new_value_i  (value_i),
      .left_value_i (left_value),
      .left_gt_i    (left_gt),
      .right_value_i(right_value),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // Results come straight from the head cell and control registers.
  assign result_valid_o = busy;
  assign sorted_value_o = cell_value[0];
  assign last_result_o  = busy && (count_q == CntW'(1));
  assign overflowed_o   = busy && ovf_q;

endmodule

### hw/rtl/ais_checker.sv
// Port-level checker of the ascending integer sorter and its bind.
module ais_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                last_item_i,
  input logic                                result_valid_o,
  input logic signed [ais_pkg::DataWidth-1:0] sorted_value_o,
  input logic                                last_result_o
);
  import ais_pkg::*;

  // A drain begins only after a closing transaction.
  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy && last_item_i))
    else $error("drain started without a closing transaction");

  // Results keep coming every cycle until the final one.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |=> result_valid_o)
    else $error("gap in result stream");

  // Final result releases the input side.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |=> !busy && !result_valid_o)
    else $error("busy held after final result");

  // Results of one set come out in ascending order.
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(result_valid_o) && !$past(last_result_o)
      |-> sorted_value_o >= $past(sorted_value_o))
    else $error("results out of order");

endmodule

bind ascending_integer_sorter ais_checker u_ais_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .last_item_i   (last_item_i),
  .result_valid_o(result_valid_o),
  .sorted_value_o(sorted_value_o),
  .last_result_o (last_result_o)
);
